// ----- rtl/core/lhct_pkg.sv -----
package lhct_pkg;

    localparam int TIME_W     = 48;
    localparam int IVL_W      = 32;
    localparam int THR_W      = 4;
    localparam int HIST_W     = 32;
    localparam int STEPS_W    = 8;
    localparam int NEED_W     = IVL_W + STEPS_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 8;

    localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SPAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_BELOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_ABOVE    = 3'd4;

    localparam logic [IVL_W-1:0] RST_MIN_INTERVAL  = 32'd300000;
    localparam logic [IVL_W-1:0] RST_INTERVAL_STEP = 32'd600000;
    localparam logic [IVL_W-1:0] RST_LIMIT_SPAN    = 32'd3600000;
    localparam logic [THR_W-1:0] RST_BAD_BELOW     = 4'd3;
    localparam logic [THR_W-1:0] RST_GOOD_ABOVE    = 4'd5;

    typedef struct packed {
        logic [IVL_W-1:0] min_interval_ms;
        logic [IVL_W-1:0] interval_step_ms;
        logic [IVL_W-1:0] limit_span_ms;
        logic [THR_W-1:0] bad_below;
        logic [THR_W-1:0] good_above;
    } t_cfg;

    typedef struct packed {
        logic              link_select;
        logic              task_ok;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic start_check;
        logic suspect_link;
    } t_result;

endpackage

// ----- rtl/core/lhct_cfg.sv -----
module lhct_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lhct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lhct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lhct_pkg::t_cfg                   o_cfg
);
    import lhct_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_INTERVAL:  n_cfg.min_interval_ms  = i_cfg_data[IVL_W-1:0];
                CFG_INTERVAL_STEP: n_cfg.interval_step_ms = i_cfg_data[IVL_W-1:0];
                CFG_LIMIT_SPAN:    n_cfg.limit_span_ms    = i_cfg_data[IVL_W-1:0];
                CFG_BAD_BELOW:     n_cfg.bad_below        = i_cfg_data[THR_W-1:0];
                CFG_GOOD_ABOVE:    n_cfg.good_above       = i_cfg_data[THR_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval_ms  <= RST_MIN_INTERVAL;
            r_cfg.interval_step_ms <= RST_INTERVAL_STEP;
            r_cfg.limit_span_ms    <= RST_LIMIT_SPAN;
            r_cfg.bad_below        <= RST_BAD_BELOW;
            r_cfg.good_above       <= RST_GOOD_ABOVE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/lhct_eval.sv -----
module lhct_eval #(
    parameter int RECENT_START = 24,
    parameter int OLDER_START  = 16,
    parameter int WINDOW_BITS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lhct_pkg::t_item     i_item,
    input  lhct_pkg::t_cfg      i_cfg,
    output lhct_pkg::t_result   o_result
);
    import lhct_pkg::*;

    // The history window starts START bits from the top; out-of-range starts fall back to one.
    localparam int RS_EFF = (RECENT_START > HIST_W || RECENT_START < 1) ? 1 : RECENT_START;
    localparam int OS_EFF = (OLDER_START > HIST_W || OLDER_START < 1) ? 1 : OLDER_START;
    localparam int RN_EFF = (RS_EFF + WINDOW_BITS > HIST_W) ? HIST_W - RS_EFF : WINDOW_BITS;
    localparam int ON_EFF = (OS_EFF + WINDOW_BITS > HIST_W) ? HIST_W - OS_EFF : WINDOW_BITS;
    localparam int R_LO   = HIST_W + 1 - RN_EFF - RS_EFF;
    localparam int O_LO   = HIST_W + 1 - ON_EFF - OS_EFF;
    localparam int CNT_W  = $clog2(WINDOW_BITS + 1) + 1;
    localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

    function automatic logic [CNT_W-1:0] count_win(
        input logic [HIST_W-1:0] hist,
        input int                lo,
        input int                nb
    );
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < WINDOW_BITS; i++) begin
            if (i < nb) begin
                cnt = cnt + CNT_W'(hist[lo + i]);
            end
        end
        return cnt;
    endfunction

    logic [HIST_W-1:0]  r_short_hist;
    logic [HIST_W-1:0]  r_long_hist;
    logic [STEPS_W-1:0] r_steps;
    logic [TIME_W-1:0]  r_last_check;
    logic [TIME_W-1:0]  r_lim_last;
    logic               r_lim_used;

    logic [HIST_W-1:0]  n_short_hist;
    logic [HIST_W-1:0]  n_long_hist;
    logic [STEPS_W-1:0] n_steps;
    logic [TIME_W-1:0]  n_last_check;
    logic [TIME_W-1:0]  n_lim_last;
    logic               n_lim_used;

    logic [CMP_W-1:0]   s_recent;
    logic [CMP_W-1:0]   s_older;
    logic [CMP_W-1:0]   l_recent;
    logic [CMP_W-1:0]   l_older;
    logic [CMP_W-1:0]   bad_thr;
    logic [CMP_W-1:0]   good_thr;
    logic               short_good;
    logic               long_good;
    logic               suspect;
    logic [TIME_W-1:0]  elapsed;
    logic [NEED_W-1:0]  need;
    logic               gate;
    logic               lim_live;
    logic [TIME_W:0]    lim_end;
    logic               allow;
    logic               fire;

    always_comb begin
        n_short_hist = r_short_hist;
        n_long_hist  = r_long_hist;
        if (i_item.link_select) begin
            n_long_hist = {r_long_hist[HIST_W-2:0], i_item.task_ok};
        end else begin
            n_short_hist = {r_short_hist[HIST_W-2:0], i_item.task_ok};
        end

        s_recent = CMP_W'(count_win(n_short_hist, R_LO, RN_EFF));
        s_older  = CMP_W'(count_win(n_short_hist, O_LO, ON_EFF));
        l_recent = CMP_W'(count_win(n_long_hist, R_LO, RN_EFF));
        l_older  = CMP_W'(count_win(n_long_hist, O_LO, ON_EFF));
        bad_thr  = CMP_W'(i_cfg.bad_below);
        good_thr = CMP_W'(i_cfg.good_above);

        short_good = s_recent > good_thr;
        long_good  = l_recent > good_thr;
        suspect    = (s_recent < bad_thr && s_older > good_thr)
                  || (l_recent < bad_thr && l_older > good_thr);

        elapsed = (i_item.now_ms < r_last_check) ? '0 : i_item.now_ms - r_last_check;
        need    = NEED_W'(i_cfg.min_interval_ms)
                + NEED_W'(r_steps) * NEED_W'(i_cfg.interval_step_ms);
        gate    = suspect && (elapsed >= TIME_W'(need));

        n_steps = r_steps;
        if (gate && r_steps != STEPS_MAX) begin
            n_steps = r_steps + 1'b1;
        end
        if (short_good && long_good) begin
            n_steps = '0;
        end

        lim_live = r_lim_used && !(i_item.now_ms < r_lim_last);
        lim_end  = {1'b0, r_lim_last} + (TIME_W + 1)'(i_cfg.limit_span_ms);
        allow    = !lim_live || ({1'b0, i_item.now_ms} > lim_end);

        n_lim_used = r_lim_used;
        n_lim_last = r_lim_last;
        if (gate) begin
            n_lim_used = 1'b1;
            if (allow) begin
                n_lim_last = i_item.now_ms;
            end
        end

        fire         = gate && allow;
        n_last_check = fire ? i_item.now_ms : r_last_check;
    end

    assign o_result.start_check  = fire;
    assign o_result.suspect_link = suspect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hist <= '0;
            r_long_hist  <= '0;
            r_steps      <= '0;
            r_last_check <= '0;
            r_lim_last   <= '0;
            r_lim_used   <= 1'b0;
        end else if (i_step) begin
            r_short_hist <= n_short_hist;
            r_long_hist  <= n_long_hist;
            r_steps      <= n_steps;
            r_last_check <= n_last_check;
            r_lim_last   <= n_lim_last;
            r_lim_used   <= n_lim_used;
        end
    end

endmodule

// ----- rtl/core/link_health_check_trigger.sv -----
// Channel   Direction  Beat contents
// s_axis    in         tuser: link_select; tdata: task_ok, now_ms[48:1], zero pad
// m_axis    out        tdata: start_check, suspect_link, zero pad
// cfg       in         register index and 32-bit write data, always ready
//
// An input beat is captured in an input register and evaluated once the output can take it.
// The result lands in an output register in the same step that updates the state.
// One beat per cycle is sustained unless the output stalls; the next state is combinational.
// Reset is synchronous and active low and clears histories, backoff and limiter.
// A stalled output holds its beat while one more input beat waits in the input register.
module link_health_check_trigger #(
    parameter int RECENT_START = 24,
    parameter int OLDER_START  = 16,
    parameter int WINDOW_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [lhct_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // task_ok, now_ms, pad
    input  logic [lhct_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,  // link_select
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [lhct_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,  // start_check, suspect_link, pad
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lhct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lhct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lhct_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_result res;
    t_result r_out;
    logic    r_out_vld;
    logic    advance;

    lhct_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lhct_eval #(
        .RECENT_START (RECENT_START),
        .OLDER_START  (OLDER_START),
        .WINDOW_BITS  (WINDOW_BITS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (res)
    );

    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(M_TDATA_W - 2){1'b0}}, r_out.suspect_link, r_out.start_check};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.link_select <= i_s_axis_tuser[0];
            r_in.task_ok     <= i_s_axis_tdata[0];
            r_in.now_ms      <= i_s_axis_tdata[TIME_W:1];
        end
        if (advance) begin
            r_out <= res;
        end
    end

endmodule
